FILE: src/tste_pkg.sv
// Shared types, constants and helpers for the tab stop text extent block.
// Used by tste_stop_ram, tste_subtract and tab_stop_text_extent_top.
`default_nettype none
package tste_pkg;

  localparam int TAB_SLOTS  = 8;
  localparam int SLOT_BITS  = $clog2(TAB_SLOTS);
  localparam int IDX_BITS   = 4;
  localparam int WIDTH_BITS = 16;
  localparam int BIT_BITS   = $clog2(WIDTH_BITS);

  localparam logic [7:0] TAB_CHAR = 8'd9;
  localparam logic [7:0] NUL_CHAR = 8'd0;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [1:0] {
    CFG_TAB_MODE     = 2'd0,
    CFG_TAB_INTERVAL = 2'd1,
    CFG_STOP_COUNT   = 2'd2,
    CFG_START_OFFSET = 2'd3
  } cfg_reg_t;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DECODE   = 8'b0000_0010,
    ST_DIV      = 8'b0000_0100,
    ST_DIV_END  = 8'b0000_1000,
    ST_SRCH_RD  = 8'b0001_0000,
    ST_SRCH_CMP = 8'b0010_0000,
    ST_TAB_END  = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_BITS-1:0]  addr;
    logic [WIDTH_BITS-1:0] data;
  } stop_wr_t;

  function automatic logic [WIDTH_BITS-1:0] sat_add(input logic [WIDTH_BITS-1:0] a,
                                                    input logic [WIDTH_BITS-1:0] b);
    logic [WIDTH_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : s[WIDTH_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/tab_stop_text_extent_top.sv
// Tab stop text extent: running pixel extent of a string, one item at a time.
// A plain character, NUL or load goes from decode straight to finish; an interval
// tab first runs 16 remainder steps on the shared subtractor; a table tab reads and compares each stop it scans.
// One item is in work at a time; input stalls until its result has passed output hold-off.
// Reset (rst, synchronous) restores the register defaults and restarts the string;
// the tab stop table holds no reset value.
`default_nettype none
module tab_stop_text_extent_top
  import tste_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic [7:0]            char_code,
  input  logic [7:0]            char_width,
  input  logic                  last,
  input  logic [SLOT_BITS-1:0]  slot,
  input  logic [WIDTH_BITS-1:0] stop_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WIDTH_BITS-1:0] extent,
  output logic [WIDTH_BITS-1:0] tab_advance,
  output logic                  end_of_string,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [WIDTH_BITS-1:0] cfg_data
);

  state_t state;

  // Configuration registers.
  logic                  tab_mode;
  logic [WIDTH_BITS-1:0] tab_interval;
  logic [IDX_BITS-1:0]   stop_count;
  logic [WIDTH_BITS-1:0] start_offset;

  // String state.
  logic [WIDTH_BITS-1:0] placed;
  logic [WIDTH_BITS-1:0] pending;
  logic [IDX_BITS-1:0]   next_idx;
  logic                  exhausted;
  logic                  nul_seen;
  logic                  mid_string;

  // Latched item and work registers.
  logic                  item_op;
  logic [7:0]            item_code;
  logic [7:0]            item_width;
  logic                  item_last;
  logic [WIDTH_BITS-1:0] tab_w;
  logic [WIDTH_BITS-1:0] rem;
  logic [BIT_BITS-1:0]   bit_cnt;
  logic [WIDTH_BITS-1:0] adv;

  logic                  accept;
  logic                  out_free;
  logic [IDX_BITS-1:0]   stop_lim;
  logic [WIDTH_BITS-1:0] iv;
  logic [WIDTH_BITS-1:0] wsum;
  logic [WIDTH_BITS:0]   sub_a;
  logic [WIDTH_BITS:0]   sub_b;
  logic [WIDTH_BITS:0]   sub_diff;
  logic                  sub_borrow;
  logic [WIDTH_BITS-1:0] stop_rd;
  stop_wr_t              stop_wr;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign stop_lim  = (stop_count > IDX_BITS'(TAB_SLOTS)) ? IDX_BITS'(TAB_SLOTS) : stop_count;
  assign iv        = (tab_interval == '0) ? WIDTH_BITS'(1) : tab_interval;
  assign wsum      = sat_add(placed, pending);

  assign stop_wr.en   = accept && (operation == OP_LOAD);
  assign stop_wr.addr = slot;
  assign stop_wr.data = stop_value;

  tste_stop_ram u_stop_ram (
    .clk     (clk),
    .wr      (stop_wr),
    .rd_addr (next_idx[SLOT_BITS-1:0]),
    .rd_data (stop_rd)
  );

  // The one subtractor serves remainder steps, the interval advance, stop compares and the extent.
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state)
      ST_DIV: begin
        sub_a = {rem, tab_w[bit_cnt]};
        sub_b = {1'b0, iv};
      end
      ST_DIV_END: begin
        sub_a = {1'b0, iv};
        sub_b = {1'b0, rem};
      end
      ST_SRCH_CMP: begin
        sub_a = {1'b0, stop_rd};
        sub_b = {1'b0, tab_w};
      end
      ST_FINISH: begin
        sub_a = {1'b0, wsum};
        sub_b = {1'b0, start_offset};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  tste_subtract u_subtract (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tab_mode     <= 1'b0;
      tab_interval <= WIDTH_BITS'(8);
      stop_count   <= '0;
      start_offset <= '0;
      placed       <= '0;
      pending      <= '0;
      next_idx     <= '0;
      exhausted    <= 1'b0;
      nul_seen     <= 1'b0;
      mid_string   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // In the finish state the output register is reloaded below instead.
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            item_op    <= operation;
            item_code  <= char_code;
            item_width <= char_width;
            item_last  <= last;
            state      <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          adv   <= '0;
          state <= ST_FINISH;
          if (item_op == OP_CHAR) begin
            if (nul_seen || item_code == NUL_CHAR) begin
              nul_seen <= 1'b1;
            end else if (item_code == TAB_CHAR) begin
              tab_w   <= wsum;
              pending <= '0;
              if (tab_mode && !exhausted) begin
                if (next_idx >= stop_lim) begin
                  exhausted <= 1'b1;
                  adv       <= WIDTH_BITS'(1);
                  state     <= ST_TAB_END;
                end else begin
                  state <= ST_SRCH_RD;
                end
              end else if (tab_mode) begin
                adv   <= WIDTH_BITS'(1);
                state <= ST_TAB_END;
              end else begin
                rem     <= '0;
                bit_cnt <= BIT_BITS'(WIDTH_BITS - 1);
                state   <= ST_DIV;
              end
            end else begin
              pending <= sat_add(pending, WIDTH_BITS'(item_width));
            end
          end
        end
        ST_DIV: begin
          // Restoring remainder step, most significant bit first.
          if (!sub_borrow) begin
            rem <= sub_diff[WIDTH_BITS-1:0];
          end else begin
            rem <= sub_a[WIDTH_BITS-1:0];
          end
          bit_cnt <= bit_cnt - BIT_BITS'(1);
          if (bit_cnt == '0) begin
            state <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          adv   <= sub_diff[WIDTH_BITS-1:0];
          state <= ST_TAB_END;
        end
        ST_SRCH_RD: begin
          state <= ST_SRCH_CMP;
        end
        ST_SRCH_CMP: begin
          next_idx <= next_idx + IDX_BITS'(1);
          if (!sub_borrow) begin
            adv   <= sub_diff[WIDTH_BITS-1:0];
            state <= ST_TAB_END;
          end else if (next_idx + IDX_BITS'(1) >= stop_lim) begin
            exhausted <= 1'b1;
            adv       <= WIDTH_BITS'(1);
            state     <= ST_TAB_END;
          end else begin
            state <= ST_SRCH_RD;
          end
        end
        ST_TAB_END: begin
          placed <= sat_add(tab_w, adv);
          state  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            extent        <= sub_borrow ? '0 : sub_diff[WIDTH_BITS-1:0];
            tab_advance   <= adv;
            end_of_string <= (item_op == OP_CHAR) && item_last;
            if (item_op == OP_CHAR) begin
              if (item_last) begin
                placed     <= start_offset;
                pending    <= '0;
                next_idx   <= '0;
                exhausted  <= 1'b0;
                nul_seen   <= 1'b0;
                mid_string <= 1'b0;
              end else begin
                mid_string <= 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TAB_MODE:     tab_mode     <= cfg_data[0];
          CFG_TAB_INTERVAL: tab_interval <= cfg_data;
          CFG_STOP_COUNT:   stop_count   <= cfg_data[IDX_BITS-1:0];
          CFG_START_OFFSET: begin
            start_offset <= cfg_data;
            if (!mid_string) begin
              placed <= cfg_data;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The table scan never runs past the end of the table.
  assert property (@(posedge clk) disable iff (rst) next_idx <= IDX_BITS'(TAB_SLOTS))
    else $error("tab stop index beyond table");

  // The partial remainder stays below the divisor during the remainder steps.
  assert property (@(posedge clk) disable iff (rst) (state == ST_DIV) |-> (rem < iv))
    else $error("remainder not below interval");

  // A tab has folded the pending run into its start width before any search step.
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_DIV || state == ST_SRCH_RD || state == ST_SRCH_CMP) |-> (pending == '0))
    else $error("pending width not cleared by tab");

  // An interval tab always advances by at least one unit.
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_DIV_END) |=> (adv != '0))
    else $error("zero advance from interval tab");

endmodule
`default_nettype wire

FILE: src/tste_stop_ram.sv
// Tab stop table: one write port and one registered read port.
// Depends on tste_pkg for the table geometry and the write struct.
`default_nettype none
module tste_stop_ram
  import tste_pkg::*;
(
  input  logic                  clk,
  input  stop_wr_t              wr,
  input  logic [SLOT_BITS-1:0]  rd_addr,
  output logic [WIDTH_BITS-1:0] rd_data
);

  logic [WIDTH_BITS-1:0] mem [TAB_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: src/tste_subtract.sv
// Shared compare and subtract unit: one wide subtraction with a borrow flag.
// Depends on tste_pkg for the datapath width.
`default_nettype none
module tste_subtract
  import tste_pkg::*;
(
  input  logic [WIDTH_BITS:0]   a,
  input  logic [WIDTH_BITS:0]   b,
  output logic [WIDTH_BITS:0]   diff,
  output logic                  borrow
);

  logic [WIDTH_BITS+1:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[WIDTH_BITS:0];
  assign borrow = full[WIDTH_BITS+1];

endmodule
`default_nettype wire

FILE: dv/tb_tab_stop_text_extent_top.sv
// Self-checking testbench for tab_stop_text_extent_top: directed and random strings,
// tab stop loads and register settings, checked against an in-bench extent predictor.
// Depends on src/tste_pkg.sv and src/tab_stop_text_extent_top.sv.
`default_nettype none
module tb_tab_stop_text_extent_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tste_pkg::*;

  localparam int unsigned WMAX        = (1 << WIDTH_BITS) - 1;
  localparam int          LIMIT       = 400000;
  localparam int          SETTLE      = 4;
  localparam int          HOLD_CYCLES = 200;
  localparam int          MAX_REPORTS = 30;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 150;

  typedef struct packed {
    logic        op;
    logic [7:0]  code;
    logic [7:0]  cw;
    logic        lst;
    logic [2:0]  slot;
    logic [15:0] stop;
  } text_item_t;

  typedef struct packed {
    logic [15:0] extent;
    logic [15:0] advance;
    logic        eos;
  } extent_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [7:0]  char_code = '0;
  logic [7:0]  char_width = '0;
  logic        last = 1'b0;
  logic [2:0]  slot = '0;
  logic [15:0] stop_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] extent;
  logic [15:0] tab_advance;
  logic        end_of_string;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tab_stop_text_extent_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .char_code(char_code), .char_width(char_width),
    .last(last), .slot(slot), .stop_value(stop_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .extent(extent), .tab_advance(tab_advance), .end_of_string(end_of_string),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the registers and the per-string state.
  logic        pm_mode;
  logic [15:0] pm_interval;
  logic [3:0]  pm_count;
  logic [15:0] pm_offset;
  int unsigned placed_w;
  int unsigned pending_w;
  int unsigned stop_idx;
  bit          tbl_done;
  bit          nul_hit;
  bit          in_string;
  int unsigned stop_tab[TAB_SLOTS];

  extent_t expected_q[$];

  int  err_count = 0;
  int  n_items = 0;
  int  n_tabs = 0;
  int  n_loads = 0;
  int  n_results = 0;
  int  n_settings = 0;
  int  cycle_count = 0;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b0;
  bit  hold_start = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  burst_left = 0;

  function automatic int unsigned clip(input int unsigned v);
    return (v > WMAX) ? WMAX : v;
  endfunction

  function automatic int unsigned extent_now();
    int unsigned w;
    w = clip(placed_w + pending_w);
    return (w > pm_offset) ? w - pm_offset : 0;
  endfunction

  function automatic void restart_string();
    placed_w  = pm_offset;
    pending_w = 0;
    stop_idx  = 0;
    tbl_done  = 1'b0;
    nul_hit   = 1'b0;
    in_string = 1'b0;
  endfunction

  function automatic void reset_predictor();
    pm_mode     = 1'b0;
    pm_interval = 16'd8;
    pm_count    = 4'd0;
    pm_offset   = 16'd0;
    foreach (stop_tab[i]) stop_tab[i] = 0;
    restart_string();
  endfunction

  // Blank width of one tab; moves the pending run into the placed width.
  function automatic int unsigned advance_tab();
    int unsigned w, adv, n, i, iv;
    w = clip(placed_w + pending_w);
    pending_w = 0;
    if (pm_mode && !tbl_done) begin
      n = (pm_count > TAB_SLOTS) ? TAB_SLOTS : pm_count;
      i = stop_idx;
      while (i < n && stop_tab[i] < w) i++;
      if (i >= n) begin
        tbl_done = 1'b1;
        adv = 1;
      end else begin
        adv = stop_tab[i] - w;
        stop_idx = i + 1;
      end
    end else begin
      iv = pm_mode ? 1 : ((pm_interval == 0) ? 1 : pm_interval);
      adv = iv - (w % iv);
    end
    placed_w = clip(w + adv);
    return adv;
  endfunction

  function automatic extent_t predict_extent(input text_item_t it);
    extent_t     r;
    int unsigned adv;
    adv = 0;
    r = '0;
    if (it.op == OP_LOAD) begin
      stop_tab[it.slot] = it.stop;
      r.extent = 16'(extent_now());
      return r;
    end
    if (nul_hit || it.code == NUL_CHAR) begin
      nul_hit = 1'b1;
    end else if (it.code == TAB_CHAR) begin
      adv = advance_tab();
    end else begin
      pending_w = clip(pending_w + it.cw);
    end
    r.extent  = 16'(extent_now());
    r.advance = 16'(adv);
    if (it.lst) begin
      r.eos = 1'b1;
      restart_string();
    end else begin
      in_string = 1'b1;
    end
    return r;
  endfunction

  function automatic text_item_t mk_char(input logic [7:0] code, input logic [7:0] cw,
                                         input logic lst);
    text_item_t it;
    it = '0;
    it.op = OP_CHAR;
    it.code = code;
    it.cw = cw;
    it.lst = lst;
    return it;
  endfunction

  function automatic text_item_t mk_load(input logic [2:0] s, input logic [15:0] v);
    text_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.slot = s;
    it.stop = v;
    return it;
  endfunction

  function automatic text_item_t random_item(input bit lst);
    text_item_t it;
    int         pick;
    it = '0;
    it.slot = 3'($urandom_range(0, 7));
    it.stop = 16'($urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 7) begin
      it.op = OP_LOAD;
      it.lst = 1'($urandom_range(0, 1));
      return it;
    end
    it.op = OP_CHAR;
    pick = $urandom_range(0, 99);
    if (pick < 22) it.code = TAB_CHAR;
    else if (pick < 24) it.code = NUL_CHAR;
    else if (pick < 34) it.code = 8'($urandom_range(0, 255));
    else it.code = 8'($urandom_range(32, 126));
    it.cw = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24));
    // A few strings are cut short by an early last.
    it.lst = lst | ($urandom_range(0, 24) == 0);
    return it;
  endfunction

  // Sends one item; valid stays high into the next item unless a gap follows.
  task automatic send_item(input text_item_t it);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= it.op;
    char_code  <= it.code;
    char_width <= it.cw;
    last       <= it.lst;
    slot       <= it.slot;
    stop_value <= it.stop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_extent(it));
    n_items++;
    if (it.op == OP_LOAD) n_loads++;
    else if (it.code == TAB_CHAR) n_tabs++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TAB_MODE:     pm_mode = val[0];
      CFG_TAB_INTERVAL: pm_interval = val;
      CFG_STOP_COUNT:   pm_count = val[3:0];
      CFG_START_OFFSET: begin
        pm_offset = val;
        // A new offset only moves the placed width before the string has begun.
        if (!in_string) placed_w = pm_offset;
      end
      default: ;
    endcase
  endtask

  task automatic set_config(input logic mode, input logic [15:0] interval,
                            input logic [3:0] count, input logic [15:0] offset);
    write_reg(CFG_TAB_MODE, {15'd0, mode});
    write_reg(CFG_TAB_INTERVAL, interval);
    write_reg(CFG_STOP_COUNT, {12'd0, count});
    write_reg(CFG_START_OFFSET, offset);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic test_interval_tabs();
    set_config(1'b0, 16'd8, 4'd0, 16'd0);
    send_item(mk_char(8'd65, 8'd255, 1'b0));
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b0));
    // The width now sits on a stop, so this tab moves a whole interval.
    send_item(mk_char(TAB_CHAR, 8'd3, 1'b0));
    send_item(mk_char(8'd255, 8'd0, 1'b0));
    send_item(mk_char(NUL_CHAR, 8'd9, 1'b0));
    send_item(mk_char(8'd66, 8'd7, 1'b0));
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b1));
    // Every slot gets loaded here, so no later table tab reads an empty slot.
    send_item(mk_load(3'd0, 16'd10));
    send_item(mk_load(3'd1, 16'd20));
    send_item(mk_load(3'd2, 16'd40));
    send_item(mk_load(3'd3, 16'd41));
    send_item(mk_load(3'd4, 16'd100));
    send_item(mk_load(3'd5, 16'd1000));
    send_item(mk_load(3'd6, 16'd30000));
    send_item(mk_load(3'd7, 16'd65535));
    wait_idle();
  endtask

  task automatic test_table_stops();
    set_config(1'b1, 16'd8, 4'd4, 16'd0);
    send_item(mk_char(8'd65, 8'd5, 1'b0));
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b0));
    send_item(mk_char(8'd66, 8'd30, 1'b0));
    // Lands exactly on a stop: zero advance.
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b0));
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b0));
    // The table is used up from here on; each tab is one unit.
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b0));
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b1));
    wait_idle();
  endtask

  task automatic test_saturation();
    set_config(1'b0, 16'd0, 4'd0, 16'd65000);
    send_item(mk_char(8'd65, 8'd255, 1'b0));
    send_item(mk_char(8'd65, 8'd255, 1'b0));
    send_item(mk_char(8'd65, 8'd255, 1'b0));
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b1));
    wait_idle();
    set_config(1'b0, 16'd65535, 4'd0, 16'd0);
    send_item(mk_char(TAB_CHAR, 8'd0, 1'b0));
    send_item(mk_char(8'd65, 8'd255, 1'b1));
    wait_idle();
  endtask

  task automatic test_offset_change();
    set_config(1'b0, 16'd8, 4'd0, 16'd10);
    send_item(mk_char(8'd65, 8'd3, 1'b0));
    wait_idle();
    // Mid-string: the larger offset drives the extent to zero until the next string.
    set_config(1'b0, 16'd8, 4'd0, 16'd50);
    send_item(mk_char(8'd66, 8'd5, 1'b1));
    send_item(mk_char(8'd67, 8'd1, 1'b1));
    wait_idle();
  endtask

  task automatic test_backpressure();
    int i;
    tx_idle = 1'b0;
    hold_start <= ~hold_start;
    for (i = 0; i < 20; i++) send_item(random_item(i == 19));
    wait_idle();
  endtask

  task automatic test_random_strings();
    int          phase, count, str_left, s;
    int unsigned pos;
    text_item_t  it;
    str_left = 0;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: set_config(1'b0, 16'($urandom_range(2, 40)), 4'd0, 16'd0);
        1: set_config(1'b1, 16'd8, 4'd8, 16'($urandom_range(0, 50)));
        2: set_config(1'b0, 16'd1, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 2000)));
        3: set_config(1'b1, 16'd3, 4'd0, 16'd0);
        4: set_config(1'b0, 16'd65535, 4'd2, 16'd65535);
        5: set_config(1'b1, 16'd0, 4'd15, 16'($urandom_range(0, 100)));
        6: set_config(1'b0, 16'($urandom_range(0, 65535)), 4'd5, 16'd0);
        default: set_config(1'b1, 16'd16, 4'($urandom_range(1, 8)),
                            16'($urandom_range(0, 300)));
      endcase
      // The closing phases run with no idling on either side.
      tx_idle = (phase < RAND_PHASES - 2);
      rx_idle <= (phase < RAND_PHASES - 2);
      count = 0;
      if (pm_mode) begin
        pos = $urandom_range(0, 20);
        for (s = 0; s < TAB_SLOTS; s++) begin
          pos += $urandom_range(1, 60);
          send_item(mk_load(3'(s), 16'(pos)));
          count++;
        end
      end
      while (count < PHASE_ITEMS) begin
        if (str_left == 0) str_left = $urandom_range(1, 14);
        it = random_item(str_left == 1);
        send_item(it);
        if (it.op == OP_CHAR) str_left = it.lst ? 0 : str_left - 1;
        count++;
      end
    end
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    extent_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: result with no item pending: expected none, actual extent %0d",
                   $time, extent);
      end else begin
        e = expected_q.pop_front();
        check_field("extent", e.extent, extent);
        check_field("tab_advance", e.advance, tab_advance);
        check_field("end_of_string", e.eos, end_of_string);
      end
    end
  end

  // Output stall: a long hold on request, otherwise short random bursts.
  always @(posedge clk) begin
    if (hold_start != hold_seen) begin
      hold_seen <= hold_start;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall <= 1'b1;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      burst_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
    test_interval_tabs();
    test_table_stops();
    test_saturation();
    test_offset_change();
    test_backpressure();
    tx_idle = 1'b1;
    test_random_strings();
    wait_idle();
    $display("Sent %0d items (%0d tabs, %0d stop loads) under %0d register settings.",
             n_items, n_tabs, n_loads, n_settings);
    $display("Compared %0d results, %0d mismatches.", n_results, err_count);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
